[design/sobel_gradient_magnitude_top_defines.svh]
// Assertion macros shared by the Sobel gradient magnitude RTL.
// Included by every module that carries concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef SOBEL_GRADIENT_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SGM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition never holds outside reset.
`define SGM_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[design/sgm_pkg.sv]
// Shared constants, types and codes of the Sobel gradient magnitude block.
// No dependencies; imported by every module of the block but sgm_ram.
`default_nettype none

package sgm_pkg;

  // Frame geometry.
  localparam int MAX_WIDTH = 1024;
  localparam int LINE_AW   = $clog2(MAX_WIDTH);
  localparam int COL_W     = LINE_AW;
  localparam int ROW_W     = 16;
  localparam int FW_W      = 11;
  localparam int FH_W      = 16;
  localparam int MIN_DIM   = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // Data path widths.
  localparam int PIX_W       = 8;
  localparam int MAG_W       = 8;
  localparam int LINE_WORD_W = 2 * PIX_W;
  localparam int KSUM_W      = PIX_W + 2;
  localparam int GRAD_W      = PIX_W + 3;
  localparam int ABS_W       = GRAD_W - 1;
  localparam int SQ_W        = 2 * ABS_W;
  localparam int SUMSQ_W     = SQ_W + 1;
  localparam int RAD_W       = 2 * MAG_W;
  localparam int REM_W       = MAG_W + 2;
  localparam int STEP_W      = $clog2(MAG_W);
  localparam logic [MAG_W-1:0] MAG_SAT = 8'd255;

  // Gradient queue.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One gradient pair handed from the front end to the back end.
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } grad_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

[design/sgm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module sgm_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/sgm_fifo.sv]
// Two-entry queue of gradient pairs between the front end and the back end.
// Depends on sgm_pkg and the assertion macros.
`default_nettype none
`include "sobel_gradient_magnitude_top_defines.svh"

module sgm_fifo import sgm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire grad_t entry_i,
  input  wire logic  pop_i,
  output grad_t      entry_o,
  output fifo_stat_t stat_o
);

  grad_t                 store_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + FIFO_CNT_W'(1);
      2'b01:   count_d = count_q - FIFO_CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o      = store_q[rd_ptr_q];
  assign stat_o.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);

  `SGM_NEVER(a_fifo_overflow, push_i && stat_o.full && !pop_i, "gradient queue overflow")
  `SGM_NEVER(a_fifo_underflow, pop_i && stat_o.empty, "gradient queue underflow")

endmodule

`default_nettype wire

[design/sgm_front.sv]
// Front end: pixel intake, raster counters, line stores and 3x3 window, Sobel gradients.
// Depends on sgm_pkg, sgm_ram and the assertion macros.
`default_nettype none
`include "sobel_gradient_magnitude_top_defines.svh"

module sgm_front import sgm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [PIX_W-1:0]      s_tdata_i,
  input  wire fifo_stat_t            fifo_stat_i,
  output logic                       push_o,
  output grad_t                      entry_o
);

  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [FW_W-1:0]  width_eff;
  logic [FH_W-1:0]  height_eff;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] win_q [6];
  logic [LINE_WORD_W-1:0] line_rd;
  logic [LINE_WORD_W-1:0] line_wr;
  logic [PIX_W-1:0] top, mid, bot;
  logic             accept, end_row, end_frame, interior;
  logic [KSUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(640);
      frame_height_q <= FH_W'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default:          frame_width_q  <= frame_width_q;
      endcase
    end
  end

  // Clamp the frame geometry to the supported range.
  always_comb begin
    priority if (frame_width_q < FW_W'(MIN_DIM)) begin
      width_eff = FW_W'(MIN_DIM);
    end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
      width_eff = FW_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width_q;
    end
    height_eff = (frame_height_q < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height_q;
  end

  // Intake and raster position.
  assign s_tready_o = !fifo_stat_i.full;
  assign accept     = s_tvalid_i && s_tready_o;
  assign end_row    = (FW_W'(col_q) + FW_W'(1)) >= width_eff;
  assign end_frame  = end_row && (({1'b0, row_q} + (ROW_W+1)'(1)) >= {1'b0, height_eff});
  assign interior   = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_frame ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Both line stores share one word: upper in the low byte, middle in the high byte.
  // The read address follows the next column, so the word is ready when the pixel arrives.
  assign top     = line_rd[PIX_W-1:0];
  assign mid     = line_rd[LINE_WORD_W-1:PIX_W];
  assign bot     = s_tdata_i;
  assign line_wr = {bot, mid};

  sgm_ram #(
    .Width (LINE_WORD_W),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (line_wr),
    .raddr_i (col_d),
    .rdata_o (line_rd)
  );

  // Window: entries 0..2 hold column c-1 (top, middle, bottom), 3..5 column c-2.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top;
      win_q[1] <= mid;
      win_q[2] <= bot;
    end
  end

  // Sobel kernels as differences of weighted column and row sums.
  assign gx_pos = KSUM_W'(top) + {1'b0, mid, 1'b0} + KSUM_W'(bot);
  assign gx_neg = KSUM_W'(win_q[3]) + {1'b0, win_q[4], 1'b0} + KSUM_W'(win_q[5]);
  assign gy_pos = KSUM_W'(win_q[5]) + {1'b0, win_q[2], 1'b0} + KSUM_W'(bot);
  assign gy_neg = KSUM_W'(win_q[3]) + {1'b0, win_q[0], 1'b0} + KSUM_W'(top);

  assign entry_o.gx   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
  assign entry_o.gy   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  assign entry_o.last = end_frame;
  assign push_o       = accept && interior;

  `SGM_ASSERT(a_front_row_wrap, accept && end_row |=> col_q == '0,
              "column did not wrap at end of row")

endmodule

`default_nettype wire

[design/sgm_back.sv]
// Back end: squares the gradients, takes the integer square root, saturates, drives results.
// Depends on sgm_pkg and the assertion macros.
`default_nettype none
`include "sobel_gradient_magnitude_top_defines.svh"

module sgm_back import sgm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire grad_t            entry_i,
  input  wire fifo_stat_t       fifo_stat_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic [MAG_W-1:0]      m_tdata_o,
  output logic                  m_tlast_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]               state_q, state_d;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic                     last_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic [RAD_W-1:0]         rad_q, rad_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [MAG_W-1:0]         root_q, root_d;
  logic                     sat_q;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [ABS_W-1:0]         ax, ay;
  logic [SUMSQ_W-1:0]       sumsq;
  logic [REM_W+1:0]         rem_sh, trial;
  logic                     out_free, load;
  logic                     m_tvalid_q;
  logic [MAG_W-1:0]         m_data_q;
  logic                     m_last_q;

  // Magnitudes, sum of squares and one root digit per step.
  assign ax     = gx_q[GRAD_W-1] ? ABS_W'(-gx_q) : ABS_W'(gx_q);
  assign ay     = gy_q[GRAD_W-1] ? ABS_W'(-gy_q) : ABS_W'(gy_q);
  assign sumsq  = SUMSQ_W'(sqx_q) + SUMSQ_W'(sqy_q);
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_q, 2'b01});

  always_comb begin
    rad_d  = rad_q << 2;
    step_d = step_q - STEP_W'(1);
    if (rem_sh >= trial) begin
      rem_d  = REM_W'(rem_sh - trial);
      root_d = {root_q[MAG_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[REM_W-1:0];
      root_d = {root_q[MAG_W-2:0], 1'b0};
    end
  end

  assign out_free = !m_tvalid_q || m_tready_i;
  assign pop_o    = (state_q == ST_IDLE) && !fifo_stat_i.empty;
  assign load     = (state_q == ST_DONE) && out_free;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (pop_o) state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_SUM;
      ST_SUM:    state_d = ST_ROOT;
      ST_ROOT:   if (step_q == '0) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the arithmetic.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      gx_q   <= entry_i.gx;
      gy_q   <= entry_i.gy;
      last_q <= entry_i.last;
    end
    if (state_q == ST_SQUARE) begin
      sqx_q <= ax * ax;
      sqy_q <= ay * ay;
    end
    if (state_q == ST_SUM) begin
      sat_q  <= |sumsq[SUMSQ_W-1:RAD_W];
      rad_q  <= sumsq[RAD_W-1:0];
      rem_q  <= '0;
      root_q <= '0;
      step_q <= STEP_W'(MAG_W - 1);
    end else if (state_q == ST_ROOT) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      step_q <= step_d;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= sat_q ? MAG_SAT : root_q;
      m_last_q <= last_q;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;

  `SGM_ASSERT(a_back_pop_starts, pop_o |=> state_q == ST_SQUARE,
              "popped entry did not start the square stage")
  `SGM_ASSERT(a_back_root_ends, state_q == ST_ROOT && step_q == '0 |=> state_q == ST_DONE,
              "root iteration did not finish after the last digit")

endmodule

`default_nettype wire

[design/sobel_gradient_magnitude_top.sv]
// Top level of the Sobel 3x3 gradient magnitude block.
// Depends on sgm_pkg, sgm_front, sgm_fifo and sgm_back.
//
//   channel  | dir | signals                         | word contents
//   ---------+-----+---------------------------------+------------------------------
//   s        | in  | s_tvalid/s_tready/s_tdata       | tdata[7:0] pixel
//   m        | out | m_tvalid/m_tready/m_tdata/tlast | tdata[7:0] magnitude, tlast last_in_frame
//   cfg      | in  | cfg_we/cfg_index/cfg_data       | 0 frame_width, 1 frame_height
//
// The front end takes one pixel per cycle while the two-entry gradient queue has room.
// Each interior result passes the back end's square, sum, root and done states; the
// square-root unit resolves one result bit per cycle; border pixels skip the back end.
// Reset clears counters, window and control; the line store needs no clearing pass.
// A run of interior pixels fills the queue, after which the input takes an interior pixel
// only when the back end pops an entry; output stalls hold the back end and stall it longer.
`default_nettype none

module sobel_gradient_magnitude_top import sgm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [PIX_W-1:0]      s_tdata_i,   // [7:0] pixel
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [MAG_W-1:0]           m_tdata_o,   // [7:0] magnitude
  output logic                       m_tlast_o
);

  grad_t      push_entry, head_entry;
  logic       push, pop;
  fifo_stat_t fifo_stat;

  sgm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  sgm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (fifo_stat)
  );

  sgm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

endmodule

`default_nettype wire

[sim/sobel_gradient_magnitude_top_test.sv]
// Self-checking testbench for the Sobel 3x3 gradient magnitude block.
// Depends on sgm_pkg and sobel_gradient_magnitude_top; it predicts every magnitude word itself.
module sobel_gradient_magnitude_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PIXELS = 300;
  localparam int PRIME_WIDTH   = 64;
  localparam int MAX_PRINTS    = 40;

  // Texture of generated pixel runs.
  typedef enum int {TEX_NOISE, TEX_FLAT, TEX_BUMPY, TEX_BINARY} texture_e;

  // One expected magnitude word.
  typedef struct {
    logic [MAG_W-1:0] mag;
    logic             last;
  } mag_word_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [MAG_W-1:0]      m_tdata;
  logic                  m_tlast;

  sobel_gradient_magnitude_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .m_tlast_o   (m_tlast)
  );

  // Predicted block state: geometry registers, line stores, window and raster position.
  bit [FW_W-1:0]  geo_width  = 11'd640;
  bit [FH_W-1:0]  geo_height = 16'd480;
  bit [PIX_W-1:0] upper_row [MAX_WIDTH];
  bit [PIX_W-1:0] middle_row [MAX_WIDTH];
  int             win [6];
  int             col_pos;
  int             row_pos;

  logic [PIX_W-1:0] pixels_to_send [$];
  mag_word_t        mags_due [$];

  bit send_gaps;
  bit recv_gaps;
  int send_idle;
  int recv_idle;
  int hold_request;
  int hold_left;
  bit pix_took;
  bit mag_took;
  int stall_cycles;
  int mismatches;
  int pixels_in;
  int mags_out;
  int frame_ends;
  int geometries;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int active_width();
    int w;
    w = geo_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = geo_height;
    if (h < MIN_DIM) h = MIN_DIM;
    return h;
  endfunction

  // Floor of the root of gx^2 + gy^2, found one result bit at a time, saturated.
  function automatic logic [MAG_W-1:0] grad_magnitude(int gx, int gy);
    int energy;
    int root;
    int trial;
    energy = gx * gx + gy * gy;
    if (energy >= 65536) return MAG_SAT;
    root = 0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= energy) root = trial;
    end
    return root[MAG_W-1:0];
  endfunction

  // Moves the window by one accepted pixel and queues the magnitude it completes, if any.
  task automatic advance_window(input logic [PIX_W-1:0] px);
    int        w, h, c, r, idx, top, mid, bot, gx, gy;
    bit        end_row, end_frame;
    mag_word_t e;
    w = active_width();
    h = active_height();
    c = col_pos;
    r = row_pos;
    idx = (c < MAX_WIDTH) ? c : 0;
    top = upper_row[idx];
    mid = middle_row[idx];
    bot = px;
    end_row = (c + 1 >= w);
    end_frame = end_row && (r + 1 >= h);
    if (r >= 2 && c >= 2) begin
      gx = (top + 2 * mid + bot) - (win[3] + 2 * win[4] + win[5]);
      gy = (win[5] + 2 * win[2] + bot) - (win[3] + 2 * win[0] + top);
      e.mag = grad_magnitude(gx, gy);
      e.last = end_frame;
      mags_due.push_back(e);
    end
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = bot;
    if (c < MAX_WIDTH) begin
      upper_row[c] = mid;
      middle_row[c] = bot;
    end
    if (end_row) begin
      col_pos = 0;
      row_pos = end_frame ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTS)
      $display("%0t: %s mismatch on word %0d: got %0d, expected %0d",
               $time, what, mags_out, got, want);
    mismatches++;
  endtask

  task automatic queue_pixels(input int count, input texture_e tex);
    int base;
    base = $urandom_range(0, 200);
    repeat (count) begin
      if ($urandom_range(0, 15) == 0) base = $urandom_range(0, 200);
      case (tex)
        TEX_NOISE:  pixels_to_send.push_back(PIX_W'($urandom_range(0, 255)));
        TEX_FLAT:   pixels_to_send.push_back(PIX_W'(base + $urandom_range(0, 31)));
        TEX_BUMPY:  pixels_to_send.push_back(PIX_W'(base[6:0] + $urandom_range(0, 63)));
        TEX_BINARY: pixels_to_send.push_back($urandom_range(0, 1) ? 8'd255 : 8'd0);
      endcase
    end
  endtask

  // Waits until every pixel is taken and every magnitude has come out, then lets
  // the back end settle on trailing border pixels.
  task automatic drain();
    while (pixels_to_send.size() != 0 || s_tvalid) @(posedge clk_i);
    while (mags_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) geo_width = value[FW_W-1:0];
    else geo_height = value[FH_W-1:0];
  endtask

  task automatic set_geometry(input int w, input int h);
    drain();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    geometries++;
  endtask

  // Samples both channels, checks results against the oldest prediction, and
  // keeps the watchdog on words that move.
  always @(posedge clk_i) begin : stream_monitor
    mag_word_t want;
    pix_took = 1'b0;
    mag_took = 1'b0;
    if (rst_ni) begin
      pix_took = s_tvalid && s_tready;
      mag_took = m_tvalid && m_tready;
      if (mag_took) begin
        if (mags_due.size() == 0) begin
          flag_mismatch("unexpected magnitude", m_tdata, -1);
        end else begin
          want = mags_due.pop_front();
          if (m_tdata !== want.mag) flag_mismatch("magnitude", m_tdata, want.mag);
          if (m_tlast !== want.last) flag_mismatch("frame end flag", m_tlast, want.last);
          else if (want.last) frame_ends++;
        end
        mags_out++;
      end
      if (pix_took) begin
        pixels_in++;
        advance_window(s_tdata);
      end
      if (pix_took || mag_took) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("sobel_gradient_magnitude_top_test: FAIL");
        $finish;
      end
    end
  end

  // Pixel sender: holds a word until taken, otherwise idles in short bursts or sends the next.
  always @(negedge clk_i) begin : pixel_driver
    if (rst_ni && !(s_tvalid && !pix_took)) begin
      if (send_idle > 0) begin
        send_idle--;
        s_tvalid <= 1'b0;
      end else if (send_gaps && pixels_to_send.size() != 0 && $urandom_range(0, 5) == 0) begin
        send_idle = $urandom_range(0, 3);
        s_tvalid <= 1'b0;
      end else if (pixels_to_send.size() != 0) begin
        s_tdata <= pixels_to_send.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Magnitude receiver: a requested long hold-off first, then random short stalls.
  always @(negedge clk_i) begin : mag_receiver
    if (rst_ni) begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle--;
        m_tready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
        recv_idle = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : run_sequence
    logic [PIX_W-1:0] edge_frame [9];
    logic [PIX_W-1:0] ramp_frame [9];
    int               w, h, n, area, pick, rand_pixels;
    texture_e         tex;

    edge_frame = '{0, 1, 255, 0, 200, 255, 0, 77, 255};
    ramp_frame = '{0, 0, 0, 100, 100, 100, 60, 60, 60};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: minimum frames reached through undersized registers; a hard
    // vertical edge that saturates, then a pure vertical gradient below saturation.
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    set_geometry(0, 2);
    foreach (edge_frame[i]) pixels_to_send.push_back(edge_frame[i]);
    set_geometry(1, 0);
    foreach (ramp_frame[i]) pixels_to_send.push_back(ramp_frame[i]);

    // A frame as wide as the widest random geometry and as tall as possible stops
    // mid-way, which writes every line entry that later widths can reach.
    set_geometry(PRIME_WIDTH, 65535);
    queue_pixels(2 * PRIME_WIDTH + 30, TEX_FLAT);

    // Narrow mid-frame, then stall the output long enough to back up the pixel input.
    set_geometry(6, 4);
    send_gaps = 1'b0;
    queue_pixels(60, TEX_BUMPY);
    hold_request = HOLD_CYCLES;

    // Random geometries and textures; runs stop at arbitrary points, so later
    // register writes often land mid-frame.
    rand_pixels = 0;
    while (rand_pixels < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) w = $urandom_range(0, 2);
      else if (pick == 1) w = $urandom_range(25, PRIME_WIDTH);
      else w = $urandom_range(3, 16);
      pick = $urandom_range(0, 9);
      if (pick == 0) h = $urandom_range(0, 2);
      else if (pick == 1) h = 65535;
      else h = $urandom_range(3, 8);
      set_geometry(w, h);
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      area = active_width() * ((active_height() > 8) ? 8 : active_height());
      n = $urandom_range(area / 2, 2 * area);
      if (n > 150) n = 150;
      pick = $urandom_range(0, 9);
      if (pick < 2) tex = TEX_NOISE;
      else if (pick < 7) tex = TEX_FLAT;
      else if (pick < 9) tex = TEX_BUMPY;
      else tex = TEX_BINARY;
      queue_pixels(n, tex);
      rand_pixels += n;
    end

    // Closing stretch at full rate on both sides.
    set_geometry(10, 5);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    queue_pixels(60, TEX_FLAT);
    drain();

    $display("Streamed %0d pixels under %0d frame geometries, clamped and changed mid-frame.",
             pixels_in, geometries);
    $display("Compared %0d magnitude words, %0d closing a frame; %0d mismatches.",
             mags_out, frame_ends, mismatches);
    if (mismatches == 0) begin
      $display("sobel_gradient_magnitude_top_test: PASS");
    end else begin
      $display("sobel_gradient_magnitude_top_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/sgm_pkg.sv
design/sgm_ram.sv
design/sgm_fifo.sv
design/sgm_front.sv
design/sgm_back.sv
design/sobel_gradient_magnitude_top.sv
sim/sobel_gradient_magnitude_top_test.sv
